### src/double_ended_queue_macros.svh
// Assertion macros used by the double-ended queue top level.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define DQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("double_ended_queue: property violated");
// Condition must never be true outside reset.
`define DQ_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("double_ended_queue: forbidden condition seen");
`else
`define DQ_ASSERT(lbl, clk, rst, prop)
`define DQ_NEVER(lbl, clk, rst, cond)
`endif
`endif

### src/dq_pkg.sv
// Package of sizes, opcodes, stage and memory request types and the ring wrap of the deque.
package dq_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = PTR_W + 2;

   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } opcode_type;

   // Operation in flight while the memory read completes
   typedef struct packed {
      logic             valid;
      logic             use_mem;
      logic             underflow;
      logic             overflow;
      logic [CNT_W-1:0] count;
   } stage_type;

   // One access to the word store
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [PTR_W-1:0]  addr;
      logic [DATA_W-1:0] wr_data;
   } mem_req_type;

   // Fold a front + offset sum (below twice the depth) back into the ring
   function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] folded;
      begin
         folded = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
         return folded[PTR_W-1:0];
      end
   endfunction

endpackage

### src/dq_if.sv
// Handshake channel interfaces for operations in and results out.
interface dq_req_if;
   logic                            valid;
   logic                            ready;
   logic [dq_pkg::OP_W-1:0]         opcode;
   logic signed [dq_pkg::DATA_W-1:0] push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface dq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [dq_pkg::DATA_W-1:0] result_value;
   logic                             underflow;
   logic                             overflow;
   logic [dq_pkg::CNT_W-1:0]         item_count;

   modport source (output valid, output result_value, output underflow,
                   output overflow, output item_count, input ready);
   modport sink   (input valid, input result_value, input underflow,
                   input overflow, input item_count, output ready);
endinterface

### src/dq_ram.sv
// Single-port synchronous RAM with registered read data.
module dq_ram #(
   parameter int DATA_W  = 32,
   parameter int ADDR_W  = 6,
   parameter int ENTRIES = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [ENTRIES];
   logic [DATA_W-1:0] rd_data_ff;

   // Write and registered read; read data holds when no read is issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/dq_ctrl.sv
// Deque control: front pointer, count, ring address and the read stage.
module dq_ctrl (
   input  logic                clock,
   input  logic                reset,
   dq_req_if.sink              req_if,
   input  logic                advance,
   output dq_pkg::mem_req_type mem_req,
   output dq_pkg::stage_type   stage
);

   logic [dq_pkg::PTR_W-1:0] front_ff, front_in;
   logic [dq_pkg::CNT_W-1:0] count_ff, count_in;
   dq_pkg::stage_type        stage_ff, stage_in, op_stage;
   logic                     accept;
   logic                     empty;
   logic                     full;
   logic [dq_pkg::PTR_W-1:0] front_dec;
   logic [dq_pkg::PTR_W-1:0] front_inc;
   logic [dq_pkg::SUM_W-1:0] tail_sum;
   logic [dq_pkg::PTR_W-1:0] tail_addr;
   logic [dq_pkg::PTR_W-1:0] last_addr;

   // Take a new beat when the stage is empty or moves on this cycle
   assign req_if.ready = !stage_ff.valid || advance;
   assign accept       = req_if.valid && req_if.ready;

   assign empty = (count_ff == '0);
   assign full  = (count_ff >= dq_pkg::COUNT_MAX);

   // Ring neighbors of the front and the back
   assign front_dec = (front_ff == '0) ? dq_pkg::PTR_LAST : front_ff - 1'b1;
   assign front_inc = (front_ff == dq_pkg::PTR_LAST) ? '0 : front_ff + 1'b1;
   assign tail_sum  = dq_pkg::SUM_W'(front_ff) + dq_pkg::SUM_W'(count_ff);
   assign tail_addr = dq_pkg::wrap_ptr(tail_sum);
   assign last_addr = dq_pkg::wrap_ptr(tail_sum - 1'b1);

   // Decode the operation into a memory access and the next pointer state
   always_comb begin
      front_in           = front_ff;
      count_in           = count_ff;
      mem_req.wr_en      = 1'b0;
      mem_req.rd_en      = 1'b0;
      mem_req.addr       = front_ff;
      mem_req.wr_data    = req_if.push_value;
      op_stage.valid     = 1'b1;
      op_stage.use_mem   = 1'b0;
      op_stage.underflow = 1'b0;
      op_stage.overflow  = 1'b0;
      unique case (dq_pkg::opcode_type'(req_if.opcode)) inside
         dq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               op_stage.overflow = 1'b1;
            end else begin
               front_in      = front_dec;
               count_in      = count_ff + 1'b1;
               mem_req.wr_en = accept;
               mem_req.addr  = front_dec;
            end
         end
         dq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               op_stage.overflow = 1'b1;
            end else begin
               count_in      = count_ff + 1'b1;
               mem_req.wr_en = accept;
               mem_req.addr  = tail_addr;
            end
         end
         dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT: begin
            if (empty) begin
               op_stage.underflow = 1'b1;
            end else begin
               op_stage.use_mem = 1'b1;
               mem_req.rd_en    = accept;
               mem_req.addr     = front_ff;
               if (req_if.opcode == dq_pkg::OP_POP_FRONT) begin
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK: begin
            if (empty) begin
               op_stage.underflow = 1'b1;
            end else begin
               op_stage.use_mem = 1'b1;
               mem_req.rd_en    = accept;
               mem_req.addr     = last_addr;
               if (req_if.opcode == dq_pkg::OP_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      op_stage.count = count_in;
   end

   // Stage register follows the read through the memory
   always_comb begin
      if (accept) begin
         stage_in = op_stage;
      end else if (advance) begin
         stage_in       = stage_ff;
         stage_in.valid = 1'b0;
      end else begin
         stage_in = stage_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
      end
   end

   assign stage = stage_ff;

endmodule

### src/double_ended_queue.sv
// Top level of the double-ended queue: store, control and result register.
// A bounded deque of 32-bit words (dq_pkg::DEPTH entries) kept in one
// single-port RAM used as a ring. Each request beat pushes, pops or peeks
// at either end; each gives exactly one response beat with the word read
// (zero for pushes, empty reads and unused opcodes), underflow and overflow
// flags and the count after the operation. One request is taken per cycle
// while the read stage is empty or moves on; a response passes through the
// registered RAM read and the response register. Pointer and count
// update when the request is taken, so a following request sees its effect
// at once. The store is not cleared at reset; only written entries are read.
`include "double_ended_queue_macros.svh"

module double_ended_queue (
   input  logic      clock,
   input  logic      reset,
   dq_req_if.sink    req_if,
   dq_rsp_if.source  rsp_if
);

   dq_pkg::mem_req_type               mem_req;
   dq_pkg::stage_type                 stage;
   logic [dq_pkg::DATA_W-1:0]         rd_data;
   logic                              out_free;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [dq_pkg::DATA_W-1:0]  rsp_value_ff;
   logic                              rsp_underflow_ff;
   logic                              rsp_overflow_ff;
   logic [dq_pkg::CNT_W-1:0]          rsp_count_ff;

   // Word store
   dq_ram #(
      .DATA_W  (dq_pkg::DATA_W),
      .ADDR_W  (dq_pkg::PTR_W),
      .ENTRIES (dq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .rd_en   (mem_req.rd_en),
      .addr    (mem_req.addr),
      .wr_data (mem_req.wr_data),
      .rd_data (rd_data)
   );

   // Pointer, count and read stage
   dq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .advance (out_free),
      .mem_req (mem_req),
      .stage   (stage)
   );

   // Response register takes the stage when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && stage.valid) begin
         rsp_value_ff     <= stage.use_mem ? rd_data : '0;
         rsp_underflow_ff <= stage.underflow;
         rsp_overflow_ff  <= stage.overflow;
         rsp_count_ff     <= stage.count;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_value = rsp_value_ff;
   assign rsp_if.underflow    = rsp_underflow_ff;
   assign rsp_if.overflow     = rsp_overflow_ff;
   assign rsp_if.item_count   = rsp_count_ff;

   // Checks
   `DQ_NEVER(a_no_rd_wr_same_cycle, clock, reset, mem_req.wr_en && mem_req.rd_en)
   `DQ_ASSERT(a_count_in_range, clock, reset, rsp_valid_ff |-> rsp_count_ff <= dq_pkg::COUNT_MAX)
   `DQ_ASSERT(a_underflow_zero, clock, reset, rsp_valid_ff && rsp_underflow_ff |-> rsp_value_ff == '0 && !rsp_overflow_ff)
   `DQ_ASSERT(a_stage_holds, clock, reset, stage.valid && !out_free |=> stage.valid)

endmodule
